### hw/rtl/write_request_coalescer_assert.svh
// assertion macros used by the checker file of the coalescer
// depends on nothing; each macro expands to one labeled concurrent assertion
`ifndef WRITE_REQUEST_COALESCER_ASSERT_SVH
`define WRITE_REQUEST_COALESCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WRC_ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("coalescer assertion failed");

// next-cycle implication, disabled during reset
`define WRC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("coalescer assertion failed");

`endif

### hw/rtl/wrc_pkg.sv
// shared types, codes and constants of the write request coalescer
// depends on nothing
`default_nettype none
package wrc_pkg;
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [2:0] OC_APPEND    = 3'd0;
  localparam logic [2:0] OC_EXTENDED  = 3'd1;
  localparam logic [2:0] OC_KEPT      = 3'd2;
  localparam logic [2:0] OC_JOINED    = 3'd3;
  localparam logic [2:0] OC_FULL      = 3'd4;

  localparam logic [1:0] REG_DBPB  = 2'd0;
  localparam logic [1:0] REG_BUF   = 2'd1;
  localparam logic [1:0] REG_GROUP = 2'd2;

  localparam logic [6:0]  DBPB_RESET  = 7'd16;
  localparam logic [15:0] BUF_RESET   = 16'd0;
  localparam logic [15:0] GROUP_RESET = 16'd0;

  typedef struct packed {
    logic        func;
    logic [31:0] source_id;
    logic [47:0] source_block;
    logic [47:0] device_block;
    logic [31:0] block_len;
  } req_t;

  typedef struct packed {
    logic [31:0] src;
    logic [47:0] sstart;
    logic [47:0] dstart;
    logic [39:0] len;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  outcome;
    logic [39:0] total_blocks;
    logic [53:0] out_source_offset;
    logic [53:0] out_device_offset;
    logic [31:0] out_length;
    logic [15:0] out_buffer;
    logic [15:0] out_group;
    logic        too_long;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [6:0]  dbpb;
    logic [15:0] buffer_id;
    logic [15:0] group_id;
  } cfg_t;
endpackage
`default_nettype wire

### hw/rtl/wrc_if.sv
// valid/ready channel interfaces for request and result beats
// depends on nothing
`default_nettype none
interface wrc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] source_id;
  logic [47:0] source_block;
  logic [47:0] device_block;
  logic [31:0] block_len;
  modport source (output valid, func, source_id, source_block, device_block, block_len,
                  input ready);
  modport sink (input valid, func, source_id, source_block, device_block, block_len,
                output ready);
endinterface

interface wrc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  outcome;
  logic [39:0] total_blocks;
  logic [53:0] out_source_offset;
  logic [53:0] out_device_offset;
  logic [31:0] out_length;
  logic [15:0] out_buffer;
  logic [15:0] out_group;
  logic        too_long;
  logic        last;
  modport source (output valid, kind, outcome, total_blocks, out_source_offset,
                  out_device_offset, out_length, out_buffer, out_group, too_long, last,
                  input ready);
  modport sink (input valid, kind, outcome, total_blocks, out_source_offset,
                out_device_offset, out_length, out_buffer, out_group, too_long, last,
                output ready);
endinterface
`default_nettype wire

### hw/rtl/wrc_ram.sv
// generic single write port, single read port ram with registered read
// depends on nothing
`default_nettype none
module wrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

### hw/rtl/wrc_front.sv
// front end: accepts request beats into a short queue for the back end
// depends on wrc_pkg and wrc_in_if
`default_nettype none
module wrc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  wrc_in_if.sink             in_ch,
  output logic               q_valid,
  output wrc_pkg::req_t      q_item,
  input  wire logic          q_pop
);
  import wrc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  req_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] fill;
  logic          push;
  logic          pop;

  assign in_ch.ready = (fill != CW'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill != '0);
  assign pop         = q_pop && q_valid;
  assign q_item      = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (pop) begin
        rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  // store each accepted beat; only the low func bit matters
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= '{func: in_ch.func, source_id: in_ch.source_id,
                     source_block: in_ch.source_block, device_block: in_ch.device_block,
                     block_len: in_ch.block_len};
    end
  end
endmodule
`default_nettype wire

### hw/rtl/wrc_back.sv
// back end: walks the entry table for enqueues, scales entries on flush,
// holds the result register; depends on wrc_pkg, wrc_out_if and wrc_ram
`default_nettype none
module wrc_back #(
  parameter int MAX_ENTRIES = wrc_pkg::DEF_MAX_ENTRIES
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire wrc_pkg::cfg_t cfg,
  input  wire logic          q_valid,
  input  wire wrc_pkg::req_t q_item,
  output logic               q_pop,
  wrc_out_if.source          out_ch
);
  import wrc_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_RES  = 5'b00100,
    S_FMUL = 5'b01000,
    S_FOUT = 5'b10000
  } state_t;

  state_t        state, state_next;
  req_t          cur, cur_next;
  logic [IW-1:0] idx, idx_next;
  logic [CW-1:0] count, count_next;
  logic [39:0]   total, total_next;
  res_t          res, res_next;
  logic          out_valid;
  res_t          out_data;

  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, e;

  logic          src_eq, same, contig, at_end, can_push;
  logic [39:0]   len40;
  logic [48:0]   s_end, d_end;
  logic [54:0]   so_prod, do_prod;
  logic [46:0]   ln_prod;

  wrc_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_ENTRIES)) u_table (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(e)
  );

  assign len40    = {8'd0, cur.block_len};
  assign s_end    = {1'b0, e.sstart} + {9'd0, e.len};
  assign d_end    = {1'b0, e.dstart} + {9'd0, e.len};
  assign src_eq   = (e.src == cur.source_id);
  assign same     = src_eq && (e.sstart == cur.source_block);
  assign contig   = src_eq && (s_end == {1'b0, cur.source_block})
                           && (d_end == {1'b0, cur.device_block});
  assign at_end   = ((CW'(idx) + CW'(1)) == count);
  assign can_push = !out_valid || out_ch.ready;
  assign so_prod  = e.sstart * cfg.dbpb;
  assign do_prod  = e.dstart * cfg.dbpb;
  assign ln_prod  = e.len * cfg.dbpb;

  always_comb begin
    state_next = state;
    cur_next   = cur;
    idx_next   = idx;
    count_next = count;
    total_next = total;
    res_next   = res;
    q_pop      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = e;
    rd_en      = 1'b0;
    rd_addr    = idx;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cur_next = q_item;
          idx_next = '0;
          res_next = '0;
          res_next.last = 1'b1;
          if (q_item.func) begin
            if (count == '0) begin
              res_next.kind = KIND_EMPTY;
              state_next    = S_RES;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = '0;
              state_next = S_FMUL;
            end
          end else if (count == '0) begin
            // empty table: append at once
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '{src: q_item.source_id, sstart: q_item.source_block,
                        dstart: q_item.device_block, len: {8'd0, q_item.block_len}};
            count_next = CW'(1);
            total_next = total + {8'd0, q_item.block_len};
            res_next.kind         = KIND_ACK;
            res_next.outcome      = OC_APPEND;
            res_next.total_blocks = total_next;
            state_next = S_RES;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        res_next.kind = KIND_ACK;
        state_next    = S_RES;
        priority if (same) begin
          if (len40 > e.len) begin
            wr_en      = 1'b1;
            wr_data.len = len40;
            total_next = total + (len40 - e.len);
            res_next.outcome = OC_EXTENDED;
          end else begin
            res_next.outcome = OC_KEPT;
          end
        end else if (contig) begin
          wr_en       = 1'b1;
          wr_data.len = e.len + len40;
          total_next  = total + len40;
          res_next.outcome = OC_JOINED;
        end else if (at_end) begin
          if (count == CW'(MAX_ENTRIES)) begin
            res_next.outcome = OC_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = count[IW-1:0];
            wr_data = '{src: cur.source_id, sstart: cur.source_block,
                        dstart: cur.device_block, len: len40};
            count_next = count + CW'(1);
            total_next = total + len40;
            res_next.outcome = OC_APPEND;
          end
        end else begin
          // keep walking
          idx_next   = idx + IW'(1);
          rd_en      = 1'b1;
          rd_addr    = idx + IW'(1);
          state_next = S_CMP;
        end
        res_next.total_blocks = total_next;
      end
      S_RES: begin
        if (can_push) begin
          state_next = S_IDLE;
        end
      end
      S_FMUL: begin
        res_next = '{kind: KIND_ENTRY, outcome: OC_APPEND, total_blocks: total,
                     out_source_offset: so_prod[53:0], out_device_offset: do_prod[53:0],
                     out_length: ln_prod[31:0], out_buffer: cfg.buffer_id,
                     out_group: cfg.group_id, too_long: |ln_prod[46:32], last: at_end};
        state_next = S_FOUT;
      end
      S_FOUT: begin
        if (can_push) begin
          if (res.last) begin
            count_next = '0;
            total_next = '0;
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + IW'(1);
            rd_en      = 1'b1;
            rd_addr    = idx + IW'(1);
            state_next = S_FMUL;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      total <= total_next;
      if ((state == S_RES || state == S_FOUT) && can_push) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    idx <= idx_next;
    res <= res_next;
    if ((state == S_RES || state == S_FOUT) && can_push) begin
      out_data <= res;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.kind              = out_data.kind;
  assign out_ch.outcome           = out_data.outcome;
  assign out_ch.total_blocks      = out_data.total_blocks;
  assign out_ch.out_source_offset = out_data.out_source_offset;
  assign out_ch.out_device_offset = out_data.out_device_offset;
  assign out_ch.out_length        = out_data.out_length;
  assign out_ch.out_buffer        = out_data.out_buffer;
  assign out_ch.out_group         = out_data.out_group;
  assign out_ch.too_long          = out_data.too_long;
  assign out_ch.last              = out_data.last;
endmodule
`default_nettype wire

### hw/rtl/write_request_coalescer.sv
// top level of the write request coalescer: register port, front and back end
// depends on wrc_pkg, wrc_if, wrc_front and wrc_back
//
// in_ch carries request beats (func 0 enqueue, func 1 flush) with valid/ready;
// a beat is taken whenever the two-deep request queue has room, even while
// the back end is busy or a result waits on out_ch.
// out_ch carries result beats: one ack per enqueue, one beat per table entry
// on a flush (last marks the final one), or one empty beat for an empty flush.
// an enqueue leaves the queue together with the first table read, is compared
// against the table entries in turn, and its ack passes through the result
// register; a new entry on an empty table is appended at once and acked the
// same way. a flush takes each entry through a scaling state, which multiplies
// the registered read of the table ram, then an output state; the single table
// read port reads the next entry only once the previous beat is registered.
// a stalled receiver holds the result register; the back end then waits and
// the queue fills, after which in_ch.ready drops.
// reset (synchronous rst) empties the queue and the table and clears the
// block total; registers return to 16, 0, 0. table contents need no clearing.
`default_nettype none
module write_request_coalescer #(
  parameter int MAX_ENTRIES = wrc_pkg::DEF_MAX_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  wrc_in_if.sink           in_ch,
  wrc_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import wrc_pkg::*;

  cfg_t cfg;
  logic q_valid, q_pop;
  req_t q_item;
  logic wr_stb;

  // register port: always ready, written in the access phase
  assign pready = 1'b1;
  assign wr_stb = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dbpb      <= DBPB_RESET;
      cfg.buffer_id <= BUF_RESET;
      cfg.group_id  <= GROUP_RESET;
    end else if (wr_stb) begin
      unique case (paddr[3:2])
        REG_DBPB:  cfg.dbpb      <= pwdata[6:0];
        REG_BUF:   cfg.buffer_id <= pwdata[15:0];
        REG_GROUP: cfg.group_id  <= pwdata[15:0];
        default: ; // no register at this address
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DBPB:  prdata = {25'd0, cfg.dbpb};
      REG_BUF:   prdata = {16'd0, cfg.buffer_id};
      REG_GROUP: prdata = {16'd0, cfg.group_id};
      default:   prdata = '0;
    endcase
  end

  // front end: request queue
  wrc_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  // back end: table walk, flush scaling, result register
  wrc_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_ch(out_ch)
  );
endmodule
`default_nettype wire

### hw/rtl/wrc_checker.sv
// port-level checks on the coalescer result channel, bound to the top level
// depends on wrc_pkg and write_request_coalescer_assert.svh
`default_nettype none
`include "write_request_coalescer_assert.svh"
module wrc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [2:0]  outcome,
  input wire logic [39:0] total_blocks,
  input wire logic [31:0] out_length,
  input wire logic        last
);
  import wrc_pkg::*;

  // a stalled result beat stays offered
  `WRC_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
  // acks are single beats with no flush payload
  `WRC_ASSERT_SAME(a_ack, clk, rst, out_valid && kind == KIND_ACK, last && out_length == '0)
  // empty flush carries nothing
  `WRC_ASSERT_SAME(a_empty, clk, rst, out_valid && kind == KIND_EMPTY,
                   last && total_blocks == '0)
  // only acks carry an outcome
  `WRC_ASSERT_SAME(a_oc, clk, rst, out_valid && kind != KIND_ACK, outcome == OC_APPEND)
endmodule

bind write_request_coalescer wrc_checker u_wrc_checker (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .kind(out_ch.kind), .outcome(out_ch.outcome), .total_blocks(out_ch.total_blocks),
  .out_length(out_ch.out_length), .last(out_ch.last)
);
`default_nettype wire

### tb/sv/tb_write_request_coalescer.sv
// testbench of the write request coalescer: directed and random request traffic
// depends on wrc_pkg, wrc_if and the write_request_coalescer top level
`timescale 1ns / 100ps
`default_nettype none
module tb_write_request_coalescer;
  import wrc_pkg::*;

  localparam int NUM_ENTRIES = DEF_MAX_ENTRIES;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [3:0] ADDR_DBPB  = 4'(REG_DBPB) << 2;
  localparam logic [3:0] ADDR_BUF   = 4'(REG_BUF) << 2;
  localparam logic [3:0] ADDR_GROUP = 4'(REG_GROUP) << 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  wrc_in_if  in_ch();
  wrc_out_if out_ch();

  write_request_coalescer uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // shadow of the block: registers, request table and running total
  cfg_t        shadow_cfg;
  entry_t      shadow_table [NUM_ENTRIES];
  int          shadow_count;
  logic [39:0] shadow_total;

  res_t expected_beats [$];
  int   error_count = 0;
  bit   no_gaps = 1'b0;  // phases with no idling on either side
  int   stall_left = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.source_id = '0;
    in_ch.source_block = '0;
    in_ch.device_block = '0;
    in_ch.block_len = '0;
    out_ch.ready = 1'b0;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // works out the beats that one accepted request causes
  function automatic void predict_request(req_t r);
    res_t b;
    logic [63:0] prod;
    logic [2:0] oc;
    bit done;
    b = '0;
    if (r.func == 1'b0) begin
      done = 1'b0;
      oc = OC_APPEND;
      for (int i = 0; i < shadow_count && !done; i++) begin
        if (shadow_table[i].src != r.source_id) continue;
        if (shadow_table[i].sstart == r.source_block) begin
          // same start: keep the longer length
          if (40'(r.block_len) > shadow_table[i].len) begin
            shadow_total = shadow_total + (40'(r.block_len) - shadow_table[i].len);
            shadow_table[i].len = 40'(r.block_len);
            oc = OC_EXTENDED;
          end else begin
            oc = OC_KEPT;
          end
          done = 1'b1;
        end else if (64'(shadow_table[i].sstart) + 64'(shadow_table[i].len)
                       == 64'(r.source_block) &&
                     64'(shadow_table[i].dstart) + 64'(shadow_table[i].len)
                       == 64'(r.device_block)) begin
          // exact sums, so a carry past 48 bits never joins
          shadow_table[i].len = shadow_table[i].len + 40'(r.block_len);
          shadow_total = shadow_total + 40'(r.block_len);
          oc = OC_JOINED;
          done = 1'b1;
        end
      end
      if (!done) begin
        if (shadow_count >= NUM_ENTRIES) begin
          oc = OC_FULL;
        end else begin
          shadow_table[shadow_count] = '{src: r.source_id, sstart: r.source_block,
                                         dstart: r.device_block, len: 40'(r.block_len)};
          shadow_count++;
          shadow_total = shadow_total + 40'(r.block_len);
        end
      end
      b.kind = KIND_ACK;
      b.outcome = oc;
      b.total_blocks = shadow_total;
      b.last = 1'b1;
      expected_beats = {expected_beats, b};
    end else if (shadow_count == 0) begin
      b.kind = KIND_EMPTY;
      b.last = 1'b1;
      expected_beats = {expected_beats, b};
    end else begin
      for (int i = 0; i < shadow_count; i++) begin
        b = '0;
        b.kind = KIND_ENTRY;
        b.outcome = OC_APPEND;
        b.total_blocks = shadow_total;
        prod = 64'(shadow_table[i].sstart) * 64'(shadow_cfg.dbpb);
        b.out_source_offset = prod[53:0];
        prod = 64'(shadow_table[i].dstart) * 64'(shadow_cfg.dbpb);
        b.out_device_offset = prod[53:0];
        prod = 64'(shadow_table[i].len) * 64'(shadow_cfg.dbpb);
        b.out_length = prod[31:0];
        b.too_long = (prod[63:32] != 0);
        b.out_buffer = shadow_cfg.buffer_id;
        b.out_group = shadow_cfg.group_id;
        b.last = (i == shadow_count - 1);
        expected_beats = {expected_beats, b};
      end
      shadow_count = 0;
      shadow_total = '0;
    end
  endfunction

  // one request beat, after a random gap
  task automatic send_request(req_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= r.func;
    in_ch.source_id <= r.source_id;
    in_ch.source_block <= r.source_block;
    in_ch.device_block <= r.device_block;
    in_ch.block_len <= r.block_len;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(r);
  endtask

  task automatic enqueue(logic [31:0] id, logic [47:0] sb, logic [47:0] db, logic [31:0] n);
    send_request('{func: 1'b0, source_id: id, source_block: sb, device_block: db,
                   block_len: n});
  endtask

  task automatic flush_table();
    send_request('{func: 1'b1, source_id: $urandom,
                   source_block: 48'({$urandom, $urandom}),
                   device_block: 48'({$urandom, $urandom}), block_len: $urandom});
  endtask

  // wait for every expected beat, then let the back end settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // idle the bus before the next setup phase
    @(posedge clk);
    case (addr)
      ADDR_DBPB:  shadow_cfg.dbpb = data[6:0];
      ADDR_BUF:   shadow_cfg.buffer_id = data[15:0];
      ADDR_GROUP: shadow_cfg.group_id = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [6:0] dbpb, logic [15:0] bid, logic [15:0] gid);
    drain();
    write_reg(ADDR_DBPB, 32'(dbpb));
    write_reg(ADDR_BUF, 32'(bid));
    write_reg(ADDR_GROUP, 32'(gid));
  endtask

  // every merge outcome on one source, then fill the table and overflow it
  task automatic test_merge_and_full();
    enqueue(32'h1, 48'd100, 48'd500, 32'd8);
    enqueue(32'h1, 48'd100, 48'd900, 32'd12);     // same start, longer
    enqueue(32'h1, 48'd100, 48'd900, 32'd3);      // same start, kept
    enqueue(32'h1, 48'd112, 48'd512, 32'd0);      // contiguous, zero length
    for (int i = 0; i < NUM_ENTRIES - 1; i++)
      enqueue(32'h100 + i, 48'(i * 1000), 48'(i * 7), 32'(i + 1));
    enqueue(32'hFFFF_FFFF, MAX48, MAX48, 32'hFFFF_FFFF);  // table full
    flush_table();
  endtask

  // scale of 64, too-long lengths, carry past 48 bits, zero scale, empty flush
  task automatic test_scaling_extremes();
    set_config(7'd64, 16'hFFFF, 16'hFFFF);
    enqueue(32'hFFFF_FFFF, MAX48, MAX48, 32'hFFFF_FFFF);
    enqueue(32'hFFFF_FFFF, MAX48 - 48'd2, 48'd0, 32'hFFFF_FFFF);
    enqueue(32'hFFFF_FFFF, 48'hFFFF_FFFC, 48'hFFFF_FFFF, 32'd1);  // wrapped sum
    flush_table();
    set_config(7'd0, 16'h0, 16'h0);
    enqueue(32'h0, 48'h8000_0000_0000, 48'h8000_0000_0000, 32'h8000_0000);
    flush_table();
    flush_table();
  endtask

  // mostly well-formed runs against live entries, some noise
  task automatic test_random_traffic(int count);
    int pick;
    int idx;
    logic [31:0] id;
    logic [47:0] sb, db;
    logic [31:0] n;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 64));
      if (pick < 8) begin
        flush_table();
      end else if (pick < 60 && shadow_count > 0) begin
        idx = $urandom_range(0, shadow_count - 1);
        id = shadow_table[idx].src;
        if (pick < 45) begin
          sb = shadow_table[idx].sstart + 48'(shadow_table[idx].len);
          db = shadow_table[idx].dstart + 48'(shadow_table[idx].len);
        end else begin
          sb = shadow_table[idx].sstart;
          db = 48'({$urandom, $urandom});
        end
        enqueue(id, sb, db, n);
      end else begin
        id = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 3));
        if ($urandom_range(0, 2) == 0) begin
          sb = 48'({$urandom, $urandom});
          db = 48'({$urandom, $urandom});
        end else begin
          sb = 48'($urandom_range(0, 4095));
          db = 48'($urandom_range(0, 4095));
        end
        enqueue(id, sb, db, n);
      end
    end
    flush_table();
  endtask

  // result side: random stall before each beat
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        stall_left = no_gaps ? 0 : $urandom_range(0, 11);
      else if (stall_left > 0)
        stall_left--;
      out_ch.ready <= (stall_left == 0);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat kind", 64'(out_ch.kind), 64'hX);
      end else begin
        want = expected_beats.pop_front();
        if (out_ch.kind !== want.kind)
          report_mismatch("kind", 64'(out_ch.kind), 64'(want.kind));
        if (out_ch.outcome !== want.outcome)
          report_mismatch("outcome", 64'(out_ch.outcome), 64'(want.outcome));
        if (out_ch.total_blocks !== want.total_blocks)
          report_mismatch("total_blocks", 64'(out_ch.total_blocks), 64'(want.total_blocks));
        if (out_ch.out_source_offset !== want.out_source_offset)
          report_mismatch("out_source_offset", 64'(out_ch.out_source_offset),
                          64'(want.out_source_offset));
        if (out_ch.out_device_offset !== want.out_device_offset)
          report_mismatch("out_device_offset", 64'(out_ch.out_device_offset),
                          64'(want.out_device_offset));
        if (out_ch.out_length !== want.out_length)
          report_mismatch("out_length", 64'(out_ch.out_length), 64'(want.out_length));
        if (out_ch.out_buffer !== want.out_buffer)
          report_mismatch("out_buffer", 64'(out_ch.out_buffer), 64'(want.out_buffer));
        if (out_ch.out_group !== want.out_group)
          report_mismatch("out_group", 64'(out_ch.out_group), 64'(want.out_group));
        if (out_ch.too_long !== want.too_long)
          report_mismatch("too_long", 64'(out_ch.too_long), 64'(want.too_long));
        if (out_ch.last !== want.last)
          report_mismatch("last", 64'(out_ch.last), 64'(want.last));
      end
    end
  end

  initial begin
    shadow_cfg = '{dbpb: DBPB_RESET, buffer_id: BUF_RESET, group_id: GROUP_RESET};
    shadow_count = 0;
    shadow_total = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_merge_and_full();
    test_scaling_extremes();
    set_config(7'd1, 16'h1234, 16'hABCD);
    test_random_traffic(70);
    set_config(7'd64, 16'hFFFF, 16'h0000);
    no_gaps = 1'b1;
    test_random_traffic(70);
    no_gaps = 1'b0;
    set_config(7'($urandom_range(1, 64)), 16'($urandom), 16'($urandom));
    test_random_traffic(70);
    set_config(7'd16, 16'h0000, 16'hFFFF);
    test_random_traffic(70);
    set_config(7'($urandom_range(1, 64)), 16'($urandom), 16'($urandom));
    test_random_traffic(60);
    drain();
    if (error_count == 0)
      $display("tb_write_request_coalescer: done, clean");
    else
      $display("tb_write_request_coalescer: done, errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_write_request_coalescer: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
+incdir+hw/rtl
hw/rtl/wrc_pkg.sv
hw/rtl/wrc_if.sv
hw/rtl/wrc_ram.sv
hw/rtl/wrc_front.sv
hw/rtl/wrc_back.sv
hw/rtl/write_request_coalescer.sv
hw/rtl/wrc_checker.sv
tb/sv/tb_write_request_coalescer.sv
